// ===== design/led_bar_countdown_timer_assert.svh =====
// Assertion macros for the LED bar countdown timer.
// Included by the modules that check their own state updates; no dependencies.
`ifndef LED_BAR_COUNTDOWN_TIMER_ASSERT_SVH
`define LED_BAR_COUNTDOWN_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent in this cycle implies consequent in the same cycle
`define LBCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// antecedent in this cycle implies consequent in the next cycle
`define LBCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define LBCT_ASSERT_NOW(label, clk, rst, ante, cons)
`define LBCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/lbct_pkg.sv =====
// Shared types, constants and the LED mask decode for the LED bar countdown timer.
// No dependencies.
package lbct_pkg;

  localparam int NUM_LEDS = 5;

  localparam int ELAPSED_W = 10;
  localparam int PERIOD_W  = 16;
  localparam int TIS_W     = 17;
  localparam int SEQ_W     = 3;

  typedef logic [NUM_LEDS-1:0]  led_mask_t;
  typedef logic [SEQ_W-1:0]     seq_state_t;
  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;
  typedef logic [TIS_W-1:0]     tis_t;
  typedef logic [1:0]           cfg_index_t;

  localparam seq_state_t SEQ_IDLE      = 3'd0;
  localparam seq_state_t SEQ_FIRST     = 3'd1;
  localparam seq_state_t SEQ_LAST      = SEQ_W'(NUM_LEDS);
  localparam seq_state_t SEQ_BLINK_OFF = SEQ_W'(NUM_LEDS + 1);
  localparam seq_state_t SEQ_BLINK_ON  = SEQ_W'(NUM_LEDS + 2);

  localparam led_mask_t ALL_LEDS = '1;
  localparam tis_t      TIS_MAX  = '1;
  localparam period_t   PERIOD_MAX = '1;

  localparam period_t BASE_PERIOD_RST  = 16'd2000;
  localparam period_t PERIOD_STEP_RST  = 16'd1000;
  localparam period_t BLINK_PERIOD_RST = 16'd1000;

  localparam cfg_index_t CFG_BASE_PERIOD  = 2'd0;
  localparam cfg_index_t CFG_PERIOD_STEP  = 2'd1;
  localparam cfg_index_t CFG_BLINK_PERIOD = 2'd2;

  typedef struct packed {
    seq_state_t state;
    logic       running;
  } seq_status_t;

  typedef struct packed {
    logic    adjust;
    period_t period;
  } adj_status_t;

  typedef struct packed {
    led_mask_t  led_mask;
    seq_state_t state;
    logic       running;
    logic       adjust;
    period_t    period;
  } result_t;

  function automatic led_mask_t mask_for(input seq_state_t s);
    led_mask_t m;
    m = '0;
    if (s == SEQ_BLINK_ON) begin
      m = ALL_LEDS;
    end else if (s >= SEQ_FIRST && s <= SEQ_LAST) begin
      m = ALL_LEDS << (s - SEQ_FIRST);
    end
    return m;
  endfunction

endpackage

// ===== design/led_bar_countdown_timer.sv =====
// LED bar countdown timer top level: input register, state update, result register.
// Depends on lbct_pkg, lbct_seq, lbct_adj and the assertion macro header.
//
// Usage: each input transaction is one debounced sample tick carrying three
// button levels and the milliseconds since the previous tick. Each tick gives
// exactly one result transaction: the lit LED mask, sequencer state, run flag,
// adjust mode and current period, all as they stand after that tick.
// Configuration: cfg_index 0 base period, 1 period step, 2 blink half period;
// other indexes are ignored. cfg_ready is always high. Writing the base period
// takes effect at the next restore only.
// Path: a tick goes from the input register to the result register, where its
// result becomes valid. Throughput: one tick per cycle unless the receiver stalls;
// each register holds one transaction; the state update between is combinational.
// Reset: synchronous; run flag off, sequencer idle, adjust mode off, period
// back to 2000 ms, registers to their defaults, both stages empty.
// Receiver stall: the result holds; one more tick waits in the input register,
// after which in_ready drops until out_ready returns.
`include "led_bar_countdown_timer_assert.svh"

module led_bar_countdown_timer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   toggle_button,
  input  logic                   up_button,
  input  logic                   restore_button,
  input  lbct_pkg::elapsed_t     elapsed_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lbct_pkg::led_mask_t    led_mask,
  output lbct_pkg::seq_state_t   sequence_state,
  output logic                   running,
  output logic                   adjust_mode,
  output lbct_pkg::period_t      period_ms,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lbct_pkg::cfg_index_t   cfg_index,
  input  lbct_pkg::period_t      cfg_data
);
  import lbct_pkg::*;

  period_t base_period, period_step, blink_half;

  logic       s1_valid;
  logic [2:0] s1_buttons;
  elapsed_t   s1_elapsed;
  logic [2:0] prev_buttons;
  logic [2:0] edges;

  logic    adv, in_fire;
  result_t res;

  seq_status_t seq_cur, seq_nxt;
  adj_status_t adj_cur, adj_nxt;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || adv;
  assign in_fire   = in_valid && in_ready;
  assign edges     = s1_buttons & ~prev_buttons;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_period  <= BASE_PERIOD_RST;
      period_step  <= PERIOD_STEP_RST;
      blink_half   <= BLINK_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_PERIOD:  base_period  <= cfg_data;
        CFG_PERIOD_STEP:  period_step  <= cfg_data;
        CFG_BLINK_PERIOD: blink_half   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      prev_buttons <= '0;
    end else begin
      if (in_fire)  s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;

      if (adv)            out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (adv) prev_buttons <= s1_buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_buttons <= {restore_button, up_button, toggle_button};
      s1_elapsed <= elapsed_ms;
    end
    if (adv) begin
      res <= '{led_mask: mask_for(seq_nxt.state), state: seq_nxt.state,
               running: seq_nxt.running, adjust: adj_nxt.adjust,
               period: adj_nxt.period};
    end
  end

  lbct_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (adv),
    .toggle_edge  (edges[0]),
    .elapsed      (s1_elapsed),
    .period       (adj_cur.period),
    .blink_half   (blink_half),
    .status       (seq_cur),
    .status_next  (seq_nxt)
  );

  lbct_adj u_adj (
    .clk          (clk),
    .rst          (rst),
    .step         (adv),
    .up_edge      (edges[1]),
    .restore_edge (edges[2]),
    .base_period  (base_period),
    .period_step  (period_step),
    .status       (adj_cur),
    .status_next  (adj_nxt)
  );

  assign led_mask       = res.led_mask;
  assign sequence_state = res.state;
  assign running        = res.running;
  assign adjust_mode    = res.adjust;
  assign period_ms      = res.period;

  // stall only when full; registered sequencer and adjuster status must match the last result sent
  `LBCT_ASSERT_NOW(a_stall_only_when_full, clk, rst, !in_ready, s1_valid && out_valid && !out_ready)
  `LBCT_ASSERT_NEXT(a_result_tracks_run, clk, rst, adv, running == seq_cur.running)
  `LBCT_ASSERT_NEXT(a_result_tracks_period, clk, rst, adv, period_ms == adj_cur.period)

endmodule

// ===== design/lbct_seq.sv =====
// Countdown sequencer: run flag, phase state and saturating time-in-state counter.
// Depends on lbct_pkg and the assertion macro header.
`include "led_bar_countdown_timer_assert.svh"

module lbct_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  toggle_edge,
  input  lbct_pkg::elapsed_t    elapsed,
  input  lbct_pkg::period_t     period,
  input  lbct_pkg::period_t     blink_half,
  output lbct_pkg::seq_status_t status,
  output lbct_pkg::seq_status_t status_next
);
  import lbct_pkg::*;

  seq_state_t state, state_next;
  logic       running, running_next;
  tis_t       tis, tis_next;
  logic [TIS_W:0] tis_sum;
  tis_t       tis_acc;
  logic       over_period, over_blink;

  always_comb begin
    tis_sum     = {1'b0, tis} + (TIS_W + 1)'(elapsed);
    tis_acc     = tis_sum[TIS_W] ? TIS_MAX : tis_sum[TIS_W-1:0];
    over_period = tis_acc > TIS_W'(period);
    over_blink  = tis_acc > TIS_W'(blink_half);

    running_next = running ^ toggle_edge;

    // decision uses the run flag from before this tick
    state_next = state;
    if (running) begin
      if (state == SEQ_IDLE) begin
        state_next = SEQ_FIRST;
      end else if (state inside {[SEQ_FIRST:SEQ_LAST]}) begin
        if (over_period) state_next = state + 3'd1;
      end else if (state == SEQ_BLINK_OFF) begin
        if (over_blink) state_next = SEQ_BLINK_ON;
      end else if (state == SEQ_BLINK_ON) begin
        if (over_blink) state_next = SEQ_BLINK_OFF;
      end
    end

    tis_next = (state_next != state) ? '0 : tis_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SEQ_IDLE;
      running <= 1'b0;
      tis     <= '0;
    end else if (step) begin
      state   <= state_next;
      running <= running_next;
      tis     <= tis_next;
    end
  end

  assign status      = '{state: state, running: running};
  assign status_next = '{state: state_next, running: running_next};

  `LBCT_ASSERT_NEXT(a_change_clears_time, clk, rst, step && state_next != state, tis == '0)
  `LBCT_ASSERT_NEXT(a_frozen_when_stopped, clk, rst, step && !running, $stable(state))
  `LBCT_ASSERT_NEXT(a_no_return_to_idle, clk, rst, state != SEQ_IDLE, state != SEQ_IDLE)

endmodule

// ===== design/lbct_adj.sv =====
// Period adjust machine: adjust mode flag and saturating step period.
// Depends on lbct_pkg and the assertion macro header.
`include "led_bar_countdown_timer_assert.svh"

module lbct_adj (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  up_edge,
  input  logic                  restore_edge,
  input  lbct_pkg::period_t     base_period,
  input  lbct_pkg::period_t     period_step,
  output lbct_pkg::adj_status_t status,
  output lbct_pkg::adj_status_t status_next
);
  import lbct_pkg::*;

  logic    adjust, adjust_next;
  period_t period, period_next;
  logic [PERIOD_W:0] sum;
  period_t sat_sum;

  always_comb begin
    sum     = {1'b0, period} + {1'b0, period_step};
    sat_sum = sum[PERIOD_W] ? PERIOD_MAX : sum[PERIOD_W-1:0];

    adjust_next = adjust;
    period_next = period;
    if (!adjust) begin
      if (up_edge) begin
        adjust_next = 1'b1;
        period_next = sat_sum;
      end
    end else if (restore_edge) begin
      // restore wins over a simultaneous up edge
      adjust_next = 1'b0;
      period_next = base_period;
    end else if (up_edge) begin
      period_next = sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust <= 1'b0;
      period <= BASE_PERIOD_RST;
    end else if (step) begin
      adjust <= adjust_next;
      period <= period_next;
    end
  end

  assign status      = '{adjust: adjust, period: period};
  assign status_next = '{adjust: adjust_next, period: period_next};

  `LBCT_ASSERT_NEXT(a_restore_reloads, clk, rst, step && adjust && restore_edge, !adjust && period == $past(base_period))
  `LBCT_ASSERT_NEXT(a_period_holds, clk, rst, step && !up_edge && !(adjust && restore_edge), $stable(period))
  `LBCT_ASSERT_NEXT(a_hold_without_step, clk, rst, !step, $stable(adjust) && $stable(period))

endmodule

// ===== sim/led_bar_countdown_timer_tb.sv =====
// Testbench for led_bar_countdown_timer: directed and random sample ticks checked
// against a cycle-free predictor of the countdown sequencer and the period adjuster.
// Depends on lbct_pkg and the led_bar_countdown_timer RTL.
module led_bar_countdown_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbct_pkg::*;

  localparam cfg_index_t CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       toggle_button;
  logic       up_button;
  logic       restore_button;
  elapsed_t   elapsed_ms;
  logic       out_valid;
  logic       out_ready;
  led_mask_t  led_mask;
  seq_state_t sequence_state;
  logic       running;
  logic       adjust_mode;
  period_t    period_ms;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  period_t    cfg_data;

  // predictor state
  logic [2:0] btn_prev;
  logic       run_on;
  seq_state_t seq;
  tis_t       seq_ms;
  logic       adj_on;
  period_t    period;
  period_t    base_reg;
  period_t    step_reg;
  period_t    blink_reg;

  result_t expected_status[$];
  int      mismatch_count;
  int      cycle_count;
  bit      in_idle_on;
  bit      out_idle_on;
  int      hold_request;
  int      hold_left;
  int      stall_left;
  int      recv_roll;

  led_bar_countdown_timer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .toggle_button  (toggle_button),
    .up_button      (up_button),
    .restore_button (restore_button),
    .elapsed_ms     (elapsed_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_mask       (led_mask),
    .sequence_state (sequence_state),
    .running        (running),
    .adjust_mode    (adjust_mode),
    .period_ms      (period_ms),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic led_mask_t lit_leds(input seq_state_t s);
    led_mask_t m;
    m = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (s == SEQ_BLINK_ON || (s >= SEQ_FIRST && s <= SEQ_LAST && i + 1 >= s)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic period_t lengthen(input period_t p);
    int s;
    s = int'(p) + int'(step_reg);
    return (s > int'(PERIOD_MAX)) ? PERIOD_MAX : period_t'(s);
  endfunction

  // one tick of the timer; the sequencer decides on the run flag and period
  // held before the tick
  task automatic predict_tick(input logic t, input logic u, input logic r,
                              input elapsed_t e);
    logic [2:0] now;
    logic [2:0] edges;
    int         ms;
    seq_state_t nxt;
    result_t    res;
    now   = {r, u, t};
    edges = now & ~btn_prev;
    ms    = int'(seq_ms) + int'(e);
    seq_ms = (ms > int'(TIS_MAX)) ? TIS_MAX : tis_t'(ms);
    nxt = seq;
    if (run_on) begin
      if (seq == SEQ_IDLE) begin
        nxt = SEQ_FIRST;
      end else if (seq <= SEQ_LAST) begin
        if (seq_ms > period) nxt = seq + 1'b1;
      end else if (seq_ms > blink_reg) begin
        nxt = (seq == SEQ_BLINK_OFF) ? SEQ_BLINK_ON : SEQ_BLINK_OFF;
      end
    end
    if (!adj_on) begin
      if (edges[1]) begin
        adj_on = 1'b1;
        period = lengthen(period);
      end
    end else if (edges[2]) begin
      adj_on = 1'b0;
      period = base_reg;
    end else if (edges[1]) begin
      period = lengthen(period);
    end
    if (edges[0]) run_on = ~run_on;
    if (nxt != seq) begin
      seq    = nxt;
      seq_ms = '0;
    end
    btn_prev = now;
    res.led_mask = lit_leds(seq);
    res.state    = seq;
    res.running  = run_on;
    res.adjust   = adj_on;
    res.period   = period;
    expected_status.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t ns: result transaction with no tick pending, expected none, actual state %0d",
                 $time, sequence_state);
        mismatch_count++;
      end else begin
        result_t want;
        want = expected_status.pop_front();
        check_field("led_mask", led_mask, want.led_mask);
        check_field("sequence_state", sequence_state, want.state);
        check_field("running", running, want.running);
        check_field("adjust_mode", adjust_mode, want.adjust);
        check_field("period_ms", period_ms, want.period);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (out_idle_on) begin
        recv_roll = $urandom_range(0, 99);
        if (recv_roll >= 96) stall_left = $urandom_range(10, 40);
        else if (recv_roll >= 75) stall_left = $urandom_range(1, 3);
      end
    end
  end

  task automatic send_tick(input logic t, input logic u, input logic r, input elapsed_t e);
    int gap;
    int roll;
    in_valid       <= 1'b1;
    toggle_button  <= t;
    up_button      <= u;
    restore_button <= r;
    elapsed_ms     <= e;
    do @(posedge clk); while (!in_ready);
    predict_tick(t, u, r, e);
    gap = 0;
    if (in_idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_ticks();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input period_t data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_PERIOD:  base_reg  = data;
      CFG_PERIOD_STEP:  step_reg  = data;
      CFG_BLINK_PERIOD: blink_reg = data;
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  // button levels flip with the given odds per tick
  task automatic random_ticks(input int count, input int toggle_pct, input int up_pct,
                              input int restore_pct);
    logic     t;
    logic     u;
    logic     r;
    elapsed_t e;
    int       roll;
    for (int k = 0; k < count; k++) begin
      t = btn_prev[0] ^ ($urandom_range(0, 99) < toggle_pct);
      u = btn_prev[1] ^ ($urandom_range(0, 99) < up_pct);
      r = btn_prev[2] ^ ($urandom_range(0, 99) < restore_pct);
      roll = $urandom_range(0, 99);
      if (roll < 10) e = '0;
      else if (roll < 20) e = '1;
      else if (roll < 55) e = elapsed_t'($urandom_range(0, 63));
      else e = elapsed_t'($urandom_range(0, 1023));
      send_tick(t, u, r, e);
    end
    stop_ticks();
  endtask

  task automatic random_registers();
    period_t v[3];
    bit      extra;
    int      roll;
    for (int i = 0; i < 3; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) v[i] = '0;
      else if (roll < 30) v[i] = PERIOD_MAX;
      else if (roll < 50) v[i] = period_t'($urandom);
      else v[i] = period_t'($urandom_range(0, 3000));
    end
    extra = ($urandom_range(0, 2) == 0);
    write_reg(CFG_BASE_PERIOD, v[0], 1'b0);
    write_reg(CFG_PERIOD_STEP, v[1], 1'b0);
    write_reg(CFG_BLINK_PERIOD, v[2], !extra);
    if (extra) write_reg(CFG_UNUSED, period_t'($urandom), 1'b1);
  endtask

  task automatic test_period_adjust();
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b1, 1'b0, 10'd5);   // enter adjust, add a step
    send_tick(1'b0, 1'b1, 1'b1, 10'd5);   // restore edge, up held
    send_tick(1'b0, 1'b0, 1'b0, 10'd5);
    send_tick(1'b0, 1'b0, 1'b1, 10'd5);   // restore outside adjust: no effect
    send_tick(1'b0, 1'b1, 1'b1, 10'd5);
    send_tick(1'b0, 1'b0, 1'b0, 10'd5);
    send_tick(1'b0, 1'b1, 1'b1, 10'd5);   // both edges in adjust: restore wins
    send_tick(1'b0, 1'b0, 1'b0, 10'd5);
    stop_ticks();
  endtask

  task automatic test_run_and_countdown();
    wait_idle();
    send_tick(1'b1, 1'b0, 1'b0, 10'd0);   // run on, sequencer still sees old flag
    send_tick(1'b1, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1000);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1000); // equal to period: no step
    send_tick(1'b0, 1'b0, 1'b0, 10'd1);
    send_tick(1'b1, 1'b0, 1'b0, 10'd1023); // run off
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b1, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b1, 1'b0, 10'd1023); // new period applies from next tick
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    stop_ticks();
  endtask

  task automatic test_random_countdown();
    wait_idle();
    write_reg(CFG_BASE_PERIOD, 16'd5000, 1'b0);
    write_reg(CFG_PERIOD_STEP, 16'd20000, 1'b0);
    write_reg(CFG_BLINK_PERIOD, 16'd1500, 1'b1);
    random_ticks(300, 3, 5, 5);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_BASE_PERIOD, '0, 1'b0);
    write_reg(CFG_PERIOD_STEP, PERIOD_MAX, 1'b0);
    write_reg(CFG_BLINK_PERIOD, '0, 1'b0);
    write_reg(CFG_UNUSED, period_t'($urandom), 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b1, 1'b0, 10'd0);    // period saturates
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b1, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 1'b1, 10'd0);    // restore to zero base
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    stop_ticks();
    wait_idle();
    write_reg(CFG_BASE_PERIOD, PERIOD_MAX, 1'b0);
    write_reg(CFG_PERIOD_STEP, '0, 1'b0);
    write_reg(CFG_BLINK_PERIOD, PERIOD_MAX, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b1, 1'b1, 10'd1023);
    send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
    stop_ticks();
  endtask

  // frozen long enough for the time in state to pin at its maximum
  task automatic test_time_saturation();
    wait_idle();
    write_reg(CFG_BLINK_PERIOD, PERIOD_MAX, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    if (run_on) send_tick(1'b1, 1'b0, 1'b0, 10'd0);
    for (int k = 0; k < 140; k++) send_tick(1'b0, 1'b0, 1'b0, '1);
    send_tick(1'b1, 1'b0, 1'b0, 10'd0);
    for (int k = 0; k < 4; k++) send_tick(1'b0, 1'b0, 1'b0, 10'd0);
    stop_ticks();
  endtask

  task automatic test_output_stall();
    wait_idle();
    in_idle_on   = 1'b0;
    hold_request = 300;
    random_ticks(40, 5, 10, 10);
    wait_idle();
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    for (int c = 0; c < 10; c++) begin
      wait_idle();
      random_registers();
      in_idle_on  = (c % 3 != 0);
      out_idle_on = (c % 4 != 1);
      random_ticks(125, 1 + 2 * c, 3 + c, 3 + c);
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    toggle_button  <= 1'b0;
    up_button      <= 1'b0;
    restore_button <= 1'b0;
    elapsed_ms     <= '0;
    out_ready      <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_BASE_PERIOD;
    cfg_data       <= '0;
    btn_prev       = '0;
    run_on         = 1'b0;
    seq            = SEQ_IDLE;
    seq_ms         = '0;
    adj_on         = 1'b0;
    base_reg       = BASE_PERIOD_RST;
    step_reg       = PERIOD_STEP_RST;
    blink_reg      = BLINK_PERIOD_RST;
    period         = BASE_PERIOD_RST;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_request   = 0;
    hold_left      = 0;
    stall_left     = 0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_period_adjust();
    test_run_and_countdown();
    test_random_countdown();
    test_register_extremes();
    test_time_saturation();
    test_output_stall();
    test_random_mix();

    wait_idle();
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
